// ----- src/mwa_pkg.sv -----
package mwa_pkg;

    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 17;
    localparam int NORM_W   = 48;
    localparam int FILL_W   = 32;
    localparam int AVG_W    = 32;
    localparam int SUM_W    = 64;
    localparam int PROD_W   = SAMPLE_W + WEIGHT_W;
    localparam int QUO_W    = 40;
    localparam int CFG_W    = 48;

    localparam logic [0:0] CFG_WEIGHT_NORM = 1'b0;
    localparam logic [0:0] CFG_FILL_WORD   = 1'b1;

    localparam logic [NORM_W-1:0] NORM_RESET = 48'd65536;
    localparam logic [FILL_W-1:0] FILL_RESET = 32'hFFFF_0000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [WEIGHT_W-1:0]        weight;
        logic                       sample_valid;
        logic                       step_last;
    } item_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] average;
        logic                    result_valid;
    } avg_t;

endpackage

// ----- src/masked_weighted_average_core.sv -----
// Masked weighted average of one timestep of grid samples.
// The item channel (item_valid, item_stall, item) carries one grid point per
// transaction: a signed Q16.16 sample, its weight, a valid bit and a mark for
// the last point of the timestep. Valid points add sample times weight,
// floored to the fraction width, into a 64-bit accumulator.
// On the last point the accumulator is divided by weight_norm and the
// saturated Q16.16 quotient leaves on the avg channel (avg_valid, avg_stall,
// avg); with no valid point in the timestep, the fill register leaves instead.
// Every transaction passes a multiply state and an accumulate state, and
// item_stall is high whenever the block is not idle, so it takes no new point
// before it is through with the last. A last point adds a check state, a
// restoring divider that resolves one quotient bit per cycle, one for each
// dividend bit, a finish step in the divider and the load of the output
// register before the next point is taken. Without a valid point the divider
// is skipped.
// The result sits in an output register, so the next timestep is taken while
// it waits; only a second result waits behind a stalled receiver.
// Reset clears the accumulator and the output valid bit, sets weight_norm to
// one and the fill register to minus one. Configuration writes via cfg_we,
// cfg_index and cfg_data take effect at once and belong between timesteps.
module masked_weighted_average_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_stall,
    input  mwa_pkg::item_t             item,
    output logic                       avg_valid,
    input  logic                       avg_stall,
    output mwa_pkg::avg_t              avg,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [mwa_pkg::CFG_W-1:0]  cfg_data
);
    import mwa_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [NORM_W-1:0]         norm_reg;
    logic [FILL_W-1:0]         fill_reg;
    item_t                     item_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic                      any_reg;
    logic [AVG_W-1:0]          res_reg;
    logic                      res_flag_reg;
    logic                      out_valid_reg;
    avg_t                      out_reg;

    logic signed [PROD_W:0]    prod_full;
    logic signed [PROD_W-1:0]  prod_shr;
    logic [SUM_W-1:0]          addend;
    logic                      div_start;
    logic                      div_done;
    logic [AVG_W-1:0]          div_q;
    logic                      load_out;

    assign prod_full = $signed(item_reg.sample) * $signed({1'b0, item_reg.weight});
    assign prod_shr  = prod_reg >>> FRAC_BITS;
    assign addend    = {{(SUM_W - PROD_W){prod_shr[PROD_W-1]}}, prod_shr};
    assign div_start = (state_reg == S_CHK) && any_reg;
    assign load_out  = (state_reg == S_FIN) && (!out_valid_reg || !avg_stall);

    mwa_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .sum      (sum_reg),
        .norm     (norm_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = item_reg.step_last ? S_CHK : S_IDLE;
            end
            S_CHK:
            begin
                state_next = any_reg ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            norm_reg      <= NORM_RESET;
            fill_reg      <= FILL_RESET;
            sum_reg       <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WEIGHT_NORM: norm_reg <= cfg_data;
                    CFG_FILL_WORD:   fill_reg <= cfg_data[FILL_W-1:0];
                    default:         norm_reg <= norm_reg;
                endcase
            end
            if (state_reg == S_ACC && item_reg.sample_valid)
            begin
                sum_reg <= sum_reg + addend;
                any_reg <= 1'b1;
            end
            else if (load_out)
            begin
                sum_reg <= '0;
                any_reg <= 1'b0;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!avg_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item_valid)
            item_reg <= item;
        if (state_reg == S_MUL)
            prod_reg <= prod_full[PROD_W-1:0];
        if (state_reg == S_CHK && !any_reg)
        begin
            res_reg      <= fill_reg;
            res_flag_reg <= 1'b0;
        end
        else if (state_reg == S_DIV && div_done)
        begin
            res_reg      <= div_q;
            res_flag_reg <= 1'b1;
        end
        if (load_out)
        begin
            out_reg.average      <= res_reg;
            out_reg.result_valid <= res_flag_reg;
        end
    end

    assign item_stall = (state_reg != S_IDLE);
    assign avg_valid  = out_valid_reg;
    assign avg        = out_reg;

endmodule

// ----- src/mwa_div.sv -----
module mwa_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [mwa_pkg::SUM_W-1:0]      sum,
    input  logic [mwa_pkg::NORM_W-1:0]     norm,
    output logic                           done,
    output logic [mwa_pkg::AVG_W-1:0]      quotient
);
    import mwa_pkg::*;

    localparam int STEPS = SUM_W + FRAC_BITS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int DVD_W = SUM_W + FRAC_BITS;

    logic [CNT_W-1:0]  cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [NORM_W-1:0] rem_reg;
    logic [QUO_W-1:0]  q_reg;
    logic              big_reg;
    logic              neg_reg;
    logic              done_reg;

    logic [NORM_W:0]   rem_sh;
    logic              ge;
    logic [NORM_W:0]   rem_sub;
    logic [SUM_W-1:0]  mag;
    logic [AVG_W-1:0]  q_neg;

    assign mag     = sum[SUM_W-1] ? (SUM_W'(0) - sum) : sum;
    assign rem_sh  = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge      = rem_sh >= {1'b0, norm};
    assign rem_sub = rem_sh - {1'b0, norm};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            else if (start)
            begin
                cnt_reg <= CNT_W'(STEPS);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[NORM_W-1:0] : rem_sh[NORM_W-1:0];
            if (q_reg[QUO_W-1])
            begin
                big_reg <= 1'b1;
                q_reg   <= '1;
            end
            else
            begin
                q_reg <= {q_reg[QUO_W-2:0], ge};
            end
        end
        else if (start)
        begin
            dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            neg_reg <= sum[SUM_W-1];
        end
    end

    assign q_neg = AVG_W'(0) - q_reg[AVG_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            if (big_reg || q_reg > 40'h00_8000_0000)
                quotient = 32'h8000_0000;
            else
                quotient = q_neg;
        end
        else
        begin
            if (big_reg || q_reg > 40'h00_7FFF_FFFF)
                quotient = 32'h7FFF_FFFF;
            else
                quotient = q_reg[AVG_W-1:0];
        end
    end

    assign done = done_reg;

endmodule
